### src/nmea_sentence_checker_defines.svh
// assertion macros shared by the nmea checker rtl
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication under an active-low reset
`define NMEA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nmea checker: same-cycle assertion failed");
// next-cycle implication under an active-low reset
`define NMEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nmea checker: next-cycle assertion failed");
`else
`define NMEA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define NMEA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/nmea_chk_pkg.sv
package nmea_chk_pkg;

    // byte counter depth and widths
    localparam int BUF_LEN   = 128;
    localparam int CNT_W     = $clog2(BUF_LEN);
    localparam int MIN_LEN_W = 7;
    localparam int CMP_W     = (CNT_W > MIN_LEN_W) ? CNT_W : MIN_LEN_W;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 7'd10;

    // special characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [5:0] HDR_LEN   = 6'd6;
    localparam logic [4:0] FIELD_MAX = 5'd31;
    localparam logic [5:0] POS_MAX   = 6'd63;

    typedef enum logic [1:0] {
        KIND_RMC   = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    typedef struct packed {
        logic       done;
        logic       ok;
        t_kind      kind;
        logic [4:0] field_index;
        logic [5:0] char_in_field;
    } t_result;

    // "$GPRMC"
    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "$GPGGA"
    function automatic logic [7:0] hdr_gga_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // nibble to upper-case ascii hex digit
    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

### src/nmea_chk_engine.sv
module nmea_chk_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_advance,
    input  logic [7:0]                           i_byte,
    input  logic [nmea_chk_pkg::MIN_LEN_W-1:0]   i_min_length,
    output nmea_chk_pkg::t_result                o_result
);
    import nmea_chk_pkg::*;
    `include "nmea_sentence_checker_defines.svh"

    logic             r_sum_active, n_sum_active;
    logic [7:0]       r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_recent [3];
    logic [7:0]       n_recent [3];
    logic [4:0]       r_comma_count, n_comma_count;
    logic [5:0]       r_field_pos, n_field_pos;
    logic             r_rmc, n_rmc;
    logic             r_gga, n_gga;

    logic             w_short_lf;
    logic             w_active;

    assign w_short_lf = (i_byte == CH_LF) &&
                        (CMP_W'(r_count) < CMP_W'(i_min_length));

    always_comb begin
        n_sum_active  = r_sum_active;
        n_sum         = r_sum;
        n_count       = r_count;
        n_recent      = r_recent;
        n_comma_count = r_comma_count;
        n_field_pos   = r_field_pos;
        n_rmc         = r_rmc;
        n_gga         = r_gga;
        w_active      = r_sum_active;

        o_result.done          = 1'b0;
        o_result.ok            = 1'b0;
        o_result.field_index   = r_comma_count;
        o_result.char_in_field = r_field_pos;

        if (!w_short_lf) begin
            if (i_byte == CH_START) begin
                n_sum_active  = 1'b1;
                n_sum         = 8'd0;
                n_count       = CNT_W'(1);
                n_comma_count = 5'd0;
                n_field_pos   = 6'd1;
                n_rmc         = 1'b1;
                n_gga         = 1'b1;
                o_result.field_index   = 5'd0;
                o_result.char_in_field = 6'd0;
            end else begin
                if (i_byte == CH_STAR) begin
                    w_active = 1'b0;
                end else if (i_byte == CH_LF) begin
                    o_result.done = 1'b1;
                    o_result.ok   = (r_recent[2] == hex_upper(r_sum[7:4])) &&
                                    (r_recent[1] == hex_upper(r_sum[3:0]));
                end
                n_sum_active = w_active;
                if (w_active) begin
                    n_sum = r_sum ^ i_byte;
                end
                // header match over the first six bytes of field zero
                if (r_comma_count == 5'd0 && r_field_pos < HDR_LEN) begin
                    if (i_byte != hdr_rmc_char(r_field_pos[2:0])) begin
                        n_rmc = 1'b0;
                    end
                    if (i_byte != hdr_gga_char(r_field_pos[2:0])) begin
                        n_gga = 1'b0;
                    end
                end
                if (i_byte == CH_COMMA) begin
                    if (r_comma_count < FIELD_MAX) begin
                        n_comma_count = r_comma_count + 5'd1;
                    end
                    n_field_pos = 6'd0;
                end else if (r_field_pos < POS_MAX) begin
                    n_field_pos = r_field_pos + 6'd1;
                end
                if (o_result.done) begin
                    n_count = '0;
                end else if (r_count == CNT_W'(BUF_LEN - 1)) begin
                    n_count = '0;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            n_recent[2] = r_recent[1];
            n_recent[1] = r_recent[0];
            n_recent[0] = i_byte;
        end

        if (n_rmc) begin
            o_result.kind = KIND_RMC;
        end else if (n_gga) begin
            o_result.kind = KIND_GGA;
        end else begin
            o_result.kind = KIND_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_active  <= 1'b0;
            r_sum         <= 8'd0;
            r_count       <= '0;
            r_recent[0]   <= 8'd0;
            r_recent[1]   <= 8'd0;
            r_recent[2]   <= 8'd0;
            r_comma_count <= 5'd0;
            r_field_pos   <= 6'd0;
            r_rmc         <= 1'b0;
            r_gga         <= 1'b0;
        end else if (i_advance) begin
            r_sum_active  <= n_sum_active;
            r_sum         <= n_sum;
            r_count       <= n_count;
            r_recent      <= n_recent;
            r_comma_count <= n_comma_count;
            r_field_pos   <= n_field_pos;
            r_rmc         <= n_rmc;
            r_gga         <= n_gga;
        end
    end

    `NMEA_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n,
        i_advance && i_byte == CH_START,
        r_comma_count == 5'd0 && r_field_pos == 6'd1 && r_count == CNT_W'(1))
    `NMEA_ASSERT_NEXT(a_done_clears_count, i_clk, i_rst_n,
        i_advance && o_result.done, r_count == '0)
    `NMEA_ASSERT_NEXT(a_star_stops_sum, i_clk, i_rst_n,
        i_advance && i_byte == CH_STAR, !r_sum_active && $stable(r_sum))

endmodule

### src/nmea_sentence_checker.sv
// channel       | dir | transaction payload
// --------------+-----+-----------------------------------------------------------
// s_axis        | in  | tdata[7:0] rx_byte
// m_axis        | out | tlast sentence_done, tuser sentence_kind,
//               |     | tdata checksum_ok / field_index / char_in_field
// i_cfg_wr_*    | in  | min_length, written whenever i_cfg_wr_en is high
//
// one byte per cycle sustained while m_axis is not stalled; a byte taken into the input
// register passes through the combinational update of the sentence state, and its result
// lands in the output register that drives m_axis, so the state loop sets the byte rate
// i_rst_n is synchronous, active low: clears all sentence state, min_length to 10
// a stalled m_axis holds the output register and the input register behind it;
// s_axis_tready drops only when both are full
module nmea_sentence_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] rx_byte
    // master side
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // [0] checksum_ok,
                                                                // [5:1] field_index,
                                                                // [11:6] char_in_field,
                                                                // [15:12] zero
    output logic                                 m_axis_tlast,  // sentence_done
    output logic [1:0]                           m_axis_tuser,  // [1:0] sentence_kind
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [nmea_chk_pkg::MIN_LEN_W-1:0]   i_cfg_wr_data
);
    import nmea_chk_pkg::*;
    `include "nmea_sentence_checker_defines.svh"

    // config register
    logic [MIN_LEN_W-1:0] r_min_length;

    // input stage
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    // output stage
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_in_accept;
    logic                 w_out_load;
    logic                 w_advance;
    t_result              w_result;

    // output register can take a new result when empty or being drained
    assign w_out_load    = !r_out_valid || m_axis_tready;
    // the held byte moves through the state update into the output register
    assign w_advance     = r_in_valid && w_out_load;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_min_length <= i_cfg_wr_data;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= w_advance;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    // sentence state and per-byte result
    nmea_chk_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_byte       (r_in_byte),
        .i_min_length (r_min_length),
        .o_result     (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {4'd0, r_out.char_in_field, r_out.field_index, r_out.ok};

    // a checksum match only ever comes with a sentence end
    `NMEA_ASSERT_IMPLIES(a_ok_needs_done, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[0], m_axis_tlast)
    // a byte held in the input stage is neither lost nor changed
    `NMEA_ASSERT_NEXT(a_in_held, i_clk, i_rst_n,
        r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte))
    // every processed byte shows up at the output
    `NMEA_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n,
        w_advance, r_out_valid)

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_chk_pkg::*;

    // generous cycle budget, well above the slowest legal run
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int BYTE_BUDGET = 1400;
    localparam int NUM_PHASES  = 7;
    localparam int HOLD_CYCLES = 400;

    // tracks sentence framing and predicts one report per received byte
    class sentence_tracker;
        t_result        expected_reports[$];
        int             errors;
        logic [6:0]     min_length;
        bit             sum_active;
        logic [7:0]     running_sum;
        int             stored_count;
        logic [7:0]     recent[3];
        logic [4:0]     comma_count;
        logic [5:0]     field_pos;
        bit             rmc_match;
        bit             gga_match;
        string          rmc_hdr = "$GPRMC";
        string          gga_hdr = "$GPGGA";
        string          hex_digits = "0123456789ABCDEF";

        function new();
            errors       = 0;
            min_length   = MIN_LEN_RST;
            sum_active   = 1'b0;
            running_sum  = 8'h00;
            stored_count = 0;
            recent[0]    = 8'h00;
            recent[1]    = 8'h00;
            recent[2]    = 8'h00;
            comma_count  = '0;
            field_pos    = '0;
            rmc_match    = 1'b0;
            gga_match    = 1'b0;
        endfunction

        function void set_min_length(logic [6:0] value);
            min_length = value;
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        function t_kind kind_now();
            if (rmc_match) return KIND_RMC;
            if (gga_match) return KIND_GGA;
            return KIND_OTHER;
        endfunction

        // one accepted byte, one predicted report
        function void take_byte(logic [7:0] b);
            t_result r;
            bit done;
            bit ok;
            done = 1'b0;
            ok   = 1'b0;
            // a line feed on a short sentence leaves all state alone
            if (b == CH_LF && stored_count < int'(min_length)) begin
                r.done          = 1'b0;
                r.ok            = 1'b0;
                r.kind          = kind_now();
                r.field_index   = comma_count;
                r.char_in_field = field_pos;
                expected_reports.push_back(r);
                return;
            end
            if (b == CH_START) begin
                running_sum  = 8'h00;
                sum_active   = 1'b1;
                stored_count = 0;
                comma_count  = '0;
                field_pos    = '0;
                rmc_match    = 1'b1;
                gga_match    = 1'b1;
            end else begin
                if (b == CH_STAR) begin
                    sum_active = 1'b0;
                end else if (b == CH_LF) begin
                    done = 1'b1;
                    ok   = (recent[2] == hex_digits[running_sum[7:4]]) &&
                           (recent[1] == hex_digits[running_sum[3:0]]);
                end
                if (sum_active) running_sum = running_sum ^ b;
                if (comma_count == 0 && field_pos < HDR_LEN) begin
                    if (b != rmc_hdr[field_pos]) rmc_match = 1'b0;
                    if (b != gga_hdr[field_pos]) gga_match = 1'b0;
                end
            end
            r.field_index   = comma_count;
            r.char_in_field = field_pos;
            if (b == CH_START) begin
                field_pos = 6'd1;
            end else if (b == CH_COMMA) begin
                if (comma_count < FIELD_MAX) comma_count = comma_count + 5'd1;
                field_pos = '0;
            end else if (field_pos < POS_MAX) begin
                field_pos = field_pos + 6'd1;
            end
            recent[2]    = recent[1];
            recent[1]    = recent[0];
            recent[0]    = b;
            stored_count = (stored_count + 1) % BUF_LEN;
            if (done) stored_count = 0;
            r.done = done;
            r.ok   = ok;
            r.kind = kind_now();
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // one accepted result against the oldest prediction
        function void match_result(logic [15:0] data, logic last, logic [1:0] user);
            t_result e;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tdata %h", $time, data);
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            compare_field("sentence_done", e.done, last);
            compare_field("checksum_ok", e.ok, data[0]);
            compare_field("sentence_kind", e.kind, user);
            compare_field("field_index", e.field_index, data[5:1]);
            compare_field("char_in_field", e.char_in_field, data[11:6]);
            compare_field("tdata padding", 0, data[15:12]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    sentence_tracker tracker = new();
    int  bytes_sent = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;          // phase with no idling on either side
    bit  hold_off_req = 1'b0;   // asks the receiver for one long stall

    nmea_sentence_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result monitor: every m_axis transaction is checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            tracker.match_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random ready pattern plus one long hold-off on request
    initial begin
        int run;
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                run = quiet ? 32 : $urandom_range(1, 12);
                m_tready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = idle_len();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // offer one byte, return at the edge where it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // stop offering and wait until every report is back, plus pipeline slack
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_length(input logic [6:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        tracker.set_min_length(value);
    endtask

    // printable field character that is not a framing character
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 126));
        while (c == CH_START || c == CH_STAR || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] payload_xor(input string s);
        logic [7:0] x;
        x = 8'h00;
        for (int i = 0; i < s.len(); i++) x = x ^ s[i];
        return x;
    endfunction

    // random sentence: header variants, random fields, good or broken tail
    function automatic string make_sentence(input int long_pct);
        string body;
        string tail;
        int    nfields;
        int    flen;
        int    pick;
        logic [7:0] sum;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: body = "GPRMC";
            4, 5, 6:    body = "GPGGA";
            7: begin
                // one header character off
                body = ($urandom_range(0, 1) != 0) ? "GPRMC" : "GPGGA";
                body[$urandom_range(0, 4)] = 8'($urandom_range(65, 90));
            end
            8: begin
                body = "";
                repeat (5) body = $sformatf("%s%c", body, 8'($urandom_range(65, 90)));
            end
            default: body = "GP";   // comma lands inside the header
        endcase
        nfields = ($urandom_range(0, 99) < 10) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        for (int f = 0; f < nfields; f++) begin
            body = {body, ","};
            flen = ($urandom_range(0, 99) < long_pct) ? $urandom_range(55, 70)
                                                       : $urandom_range(0, 7);
            repeat (flen) body = $sformatf("%s%c", body, field_char());
        end
        sum  = payload_xor(body);
        pick = $urandom_range(0, 99);
        if (pick < 70)      tail = $sformatf("*%02X", sum);
        else if (pick < 80) tail = $sformatf("*%02X", sum ^ (8'h01 << $urandom_range(0, 7)));
        else if (pick < 88) tail = $sformatf("*%02x", sum);
        else                tail = "";
        if ($urandom_range(0, 99) < 92) tail = {tail, "\r\n"};
        else                            tail = {tail, "\n"};
        return {"$", body, tail};
    endfunction

    // stray bytes, four in ten of them framing characters
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       send_byte(CH_START);
                1:       send_byte(CH_STAR);
                2:       send_byte(CH_COMMA);
                3:       send_byte(CH_LF);
                4:       send_byte(8'h0D);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        logic [6:0] plan[NUM_PHASES];
        int long_pct;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes before any start byte, short line feed, kind other
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_LF);
        // no minimum: line feed ends at once and compares against the few bytes held
        write_min_length(7'd0);
        send_byte(CH_LF);
        // well-formed sentence with a correct checksum
        send_string({"$GPGGA,*", $sformatf("%02X", payload_xor("GPGGA,")), "\r\n"});
        // header alone with no star, summing runs through cr and line feed
        send_string("$GPRMC\r\n");

        plan[0] = 7'd10;
        plan[1] = 7'd0;
        plan[2] = 7'd127;
        plan[3] = 7'($urandom_range(0, 127));
        plan[4] = 7'd1;
        plan[5] = 7'($urandom_range(5, 40));
        plan[6] = 7'd10;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_min_length(plan[p]);
            quiet = (p == 4);
            // long sentences in the max-length phase make the count wrap
            long_pct = (p == 2) ? 25 : 3;
            if (p == 3) hold_off_req = 1'b1;
            while (bytes_sent < (p + 1) * BYTE_BUDGET / NUM_PHASES) begin
                if ($urandom_range(0, 99) < 15) send_noise();
                else send_string(make_sentence(long_pct));
            end
        end
        quiet = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
